// ===== rtl/core/fpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types, constants and helpers of the frame position map.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int MAX_SEGMENTS    = 64;
  localparam int IDX_W           = $clog2(MAX_SEGMENTS);
  localparam int CNT_W           = IDX_W + 1;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int POS_W           = 48;
  localparam int LEN_W           = 24;
  localparam int RATIO_W         = 24;
  localparam int FCNT_W          = 20;
  localparam int BACKLOG_W       = 23;
  localparam int OP_W            = 2;
  localparam int PROD_W          = LEN_W + RATIO_W;
  localparam int SCALED_W        = PROD_W + 1 - RATIO_FRAC_BITS;
  localparam int DIST_W          = 31;
  localparam int TOTAL_W         = LEN_W + 1;
  localparam int IN_DATA_W       = 144;
  localparam int OUT_DATA_W      = 48;

  localparam logic [BACKLOG_W-1:0] BACKLOG_RESET = BACKLOG_W'(100000);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NONE      = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LATCH     = 5'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 5'd2;
  localparam logic [CMD_W-1:0] CMD_RD_NEWEST = 5'd3;
  localparam logic [CMD_W-1:0] CMD_MUL_SEG   = 5'd4;
  localparam logic [CMD_W-1:0] CMD_MERGE_CHK = 5'd5;
  localparam logic [CMD_W-1:0] CMD_APP_IN    = 5'd6;
  localparam logic [CMD_W-1:0] CMD_WR_LEN    = 5'd7;
  localparam logic [CMD_W-1:0] CMD_SPLIT_D   = 5'd8;
  localparam logic [CMD_W-1:0] CMD_SPLIT_MUL = 5'd9;
  localparam logic [CMD_W-1:0] CMD_APP_SPLIT = 5'd10;
  localparam logic [CMD_W-1:0] CMD_APPEND    = 5'd11;
  localparam logic [CMD_W-1:0] CMD_CL_RD     = 5'd12;
  localparam logic [CMD_W-1:0] CMD_CL_ACC    = 5'd13;
  localparam logic [CMD_W-1:0] CMD_CL_END    = 5'd14;
  localparam logic [CMD_W-1:0] CMD_SR_EMPTY  = 5'd15;
  localparam logic [CMD_W-1:0] CMD_SR_START  = 5'd16;
  localparam logic [CMD_W-1:0] CMD_SR_EVAL   = 5'd17;
  localparam logic [CMD_W-1:0] CMD_SR_NEXT   = 5'd18;
  localparam logic [CMD_W-1:0] CMD_SR_FIN    = 5'd19;
  localparam logic [CMD_W-1:0] CMD_SR_HITMUL = 5'd20;
  localparam logic [CMD_W-1:0] CMD_SR_HITRES = 5'd21;
  localparam logic [CMD_W-1:0] CMD_LOAD_OUT  = 5'd22;

  typedef struct packed {
    logic [POS_W-1:0]   src;
    logic [POS_W-1:0]   dest;
    logic [LEN_W-1:0]   len;
    logic [RATIO_W-1:0] ratio;
  } seg_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic merge;
    logic split;
    logic clean_go;
    logic hit;
    logic last;
  } stat_t;

  function automatic logic [SCALED_W-1:0] fpm_round(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] s;
    s = {1'b0, p} + ((PROD_W+1)'(1) << (RATIO_FRAC_BITS - 1));
    return s[PROD_W:RATIO_FRAC_BITS];
  endfunction

  function automatic logic [DIST_W-1:0] fpm_sat(input logic [POS_W:0] v);
    logic [DIST_W-1:0] r;
    r = (|v[POS_W:DIST_W]) ? {DIST_W{1'b1}} : v[DIST_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/frame_position_map.sv =====
// ----------------------------------------------------------------------------
// frame_position_map
// Ring of segments mapping source frames to destination frames.
// ----------------------------------------------------------------------------
// Insert: one of four paths (empty ring, merge, append or split), then a cleanup
// walk over the segments it keeps. Search scans the ring from the oldest segment and
// stops at the first hit; an empty ring gives an approximate zero result. Search
// waits while the previous result still waits at the output.
// Clear empties the ring. One request is worked on at a time; a finished result
// waits in the output register while the next request is taken.
// Synchronous active-low reset empties the table and sets the backlog to 100000.
module frame_position_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Operation.
  input  logic [fpm_pkg::OP_W-1:0]            in_tuser,
  // Source frame, frame count, destination frame, ratio, zero padding.
  input  logic [fpm_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Mapped frame.
  output logic [fpm_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Approximate flag.
  output logic                                out_tuser,
  input  logic                                cfg_wen,
  input  logic [fpm_pkg::BACKLOG_W-1:0]       cfg_wdata
);

  fpm_pkg::cmd_t  cmd;
  fpm_pkg::stat_t stat;

  fpm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  fpm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== rtl/core/fpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpm_ctrl
// Sequencer of the frame position map: steps inserts, cleanup, clears and searches.
// ----------------------------------------------------------------------------
module fpm_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [fpm_pkg::OP_W-1:0] in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output fpm_pkg::cmd_t            cmd,
  input  fpm_pkg::stat_t           stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_I0   = 4'd1;
  localparam logic [3:0] S_I1   = 4'd2;
  localparam logic [3:0] S_I2   = 4'd3;
  localparam logic [3:0] S_I3   = 4'd4;
  localparam logic [3:0] S_I4   = 4'd5;
  localparam logic [3:0] S_I5   = 4'd6;
  localparam logic [3:0] S_APP  = 4'd7;
  localparam logic [3:0] S_CL0  = 4'd8;
  localparam logic [3:0] S_CL1  = 4'd9;
  localparam logic [3:0] S_SR0  = 4'd10;
  localparam logic [3:0] S_SR1  = 4'd11;
  localparam logic [3:0] S_SR2  = 4'd12;
  localparam logic [3:0] S_SR3  = 4'd13;
  localparam logic [3:0] S_SRF  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = fpm_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = fpm_pkg::CMD_LATCH;
          case (in_tuser)
            fpm_pkg::OP_INSERT: state_nxt = S_I0;
            fpm_pkg::OP_SEARCH: state_nxt = S_SR0;
            fpm_pkg::OP_CLEAR:  state_nxt = S_CL1;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_I0: begin
        if (stat.count_zero) begin
          cmd.op    = fpm_pkg::CMD_APP_IN;
          state_nxt = S_APP;
        end else begin
          cmd.op    = fpm_pkg::CMD_RD_NEWEST;
          state_nxt = S_I1;
        end
      end
      S_I1: begin
        cmd.op    = fpm_pkg::CMD_MUL_SEG;
        state_nxt = S_I2;
      end
      S_I2: begin
        cmd.op    = fpm_pkg::CMD_MERGE_CHK;
        state_nxt = S_I3;
      end
      S_I3: begin
        if (!stat.merge) begin
          cmd.op    = fpm_pkg::CMD_APP_IN;
          state_nxt = S_APP;
        end else if (stat.split) begin
          cmd.op    = fpm_pkg::CMD_SPLIT_D;
          state_nxt = S_I4;
        end else begin
          cmd.op    = fpm_pkg::CMD_WR_LEN;
          state_nxt = S_CL0;
        end
      end
      S_I4: begin
        cmd.op    = fpm_pkg::CMD_SPLIT_MUL;
        state_nxt = S_I5;
      end
      S_I5: begin
        cmd.op    = fpm_pkg::CMD_APP_SPLIT;
        state_nxt = S_APP;
      end
      S_APP: begin
        cmd.op    = fpm_pkg::CMD_APPEND;
        state_nxt = S_CL0;
      end
      S_CL0: begin
        if (stat.clean_go) begin
          cmd.op    = fpm_pkg::CMD_CL_RD;
          state_nxt = S_CL1;
        end else begin
          cmd.op    = fpm_pkg::CMD_CL_END;
          state_nxt = S_IDLE;
        end
      end
      S_CL1: begin
        // Also serves the clear request, which is recognised in the datapath.
        cmd.op    = fpm_pkg::CMD_CL_ACC;
        state_nxt = S_CL0;
      end
      S_SR0: begin
        if (stat.count_zero) begin
          cmd.op    = fpm_pkg::CMD_SR_EMPTY;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = fpm_pkg::CMD_SR_START;
          state_nxt = S_SR1;
        end
      end
      S_SR1: begin
        cmd.op    = fpm_pkg::CMD_SR_EVAL;
        state_nxt = S_SR2;
      end
      S_SR2: begin
        if (stat.hit) begin
          cmd.op    = fpm_pkg::CMD_SR_HITMUL;
          state_nxt = S_SR3;
        end else begin
          cmd.op    = fpm_pkg::CMD_SR_NEXT;
          state_nxt = stat.last ? S_SRF : S_SR1;
        end
      end
      S_SR3: begin
        cmd.op    = fpm_pkg::CMD_SR_HITRES;
        state_nxt = S_OUT;
      end
      S_SRF: begin
        cmd.op    = fpm_pkg::CMD_SR_FIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          cmd.op    = fpm_pkg::CMD_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.op == fpm_pkg::CMD_LOAD_OUT) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ===== rtl/core/fpm_dp.sv =====
// ----------------------------------------------------------------------------
// fpm_dp
// Datapath of the frame position map: segment memory, multiplier and scratch.
// ----------------------------------------------------------------------------
module fpm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpm_pkg::cmd_t                       cmd,
  output fpm_pkg::stat_t                      stat,
  input  logic [fpm_pkg::OP_W-1:0]            in_tuser,
  input  logic [fpm_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                cfg_wen,
  input  logic [fpm_pkg::BACKLOG_W-1:0]       cfg_wdata,
  output logic [fpm_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tuser
);

  localparam int PW = fpm_pkg::POS_W;
  localparam int IW = fpm_pkg::IDX_W;
  localparam int CW = fpm_pkg::CNT_W;
  localparam int LW = fpm_pkg::LEN_W;

  fpm_pkg::seg_t mem [fpm_pkg::MAX_SEGMENTS];
  fpm_pkg::seg_t rd_r, app_r, wr_data;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          rd_en, wr_en;

  logic [fpm_pkg::OP_W-1:0]      op_r;
  logic [PW-1:0]                 src_r, dst_r;
  logic [fpm_pkg::FCNT_W-1:0]    cnt_r;
  logic [fpm_pkg::RATIO_W-1:0]   rat_r;
  logic [IW-1:0]                 oldest_r;
  logic [CW-1:0]                 count_r, keep_r, k_r;
  logic [fpm_pkg::BACKLOG_W-1:0] backlog_r;
  logic [IW-1:0]                 nidx_r;
  logic [fpm_pkg::PROD_W-1:0]    prod_r;
  logic                          merge_r, hit_r;
  logic [LW-1:0]                 len_r, d_r, off_r;
  logic [fpm_pkg::TOTAL_W-1:0]   total_r;
  logic [fpm_pkg::DIST_W-1:0]    ds_r, de_r, best_d_r;
  logic [PW-1:0]                 best_p_r, res_p_r, out_p_r;
  logic                          res_a_r, out_a_r;

  logic [PW:0]                   src_end, proj;
  logic [PW+1:0]                 pdiff;
  logic [LW:0]                   lsum;
  logic [LW-1:0]                 mul_a;
  logic [fpm_pkg::RATIO_W-1:0]   mul_b;
  logic [fpm_pkg::PROD_W-1:0]    mul_p;
  logic                          c_src, c_rat, c_dst, s_hit;
  logic [PW:0]                   ad_s, ad_e;
  logic [fpm_pkg::DIST_W-1:0]    b1_d;
  logic [PW-1:0]                 b1_p, end_pos;
  logic [CW-1:0]                 k_inc;

  assign out_tdata = out_p_r;
  assign out_tuser = out_a_r;

  assign mul_p = fpm_pkg::PROD_W'(mul_a) * fpm_pkg::PROD_W'(mul_b);

  // Merge test on the newest segment.
  assign src_end = {1'b0, rd_r.src} + (PW+1)'(rd_r.len);
  assign proj    = {1'b0, rd_r.dest} + (PW+1)'(fpm_pkg::fpm_round(prod_r));
  assign pdiff   = {1'b0, proj} - {2'b00, dst_r};
  assign c_src   = (src_end == {1'b0, src_r});
  assign c_rat   = (rd_r.ratio == rat_r);
  assign c_dst   = (pdiff == '0) || (pdiff == (PW+2)'(1)) || (pdiff == '1);
  assign lsum    = {1'b0, rd_r.len} + (LW+1)'(cnt_r);

  // Search evaluation of one segment.
  assign s_hit = (src_r >= rd_r.src) && ({1'b0, src_r} < src_end);
  assign ad_s  = (src_r >= rd_r.src) ? {1'b0, src_r - rd_r.src} : {1'b0, rd_r.src - src_r};
  assign ad_e  = ({1'b0, src_r} >= src_end) ? ({1'b0, src_r} - src_end)
                                            : (src_end - {1'b0, src_r});
  assign end_pos = rd_r.dest + PW'(fpm_pkg::fpm_round(prod_r));
  assign b1_d    = (ds_r < best_d_r) ? ds_r : best_d_r;
  assign b1_p    = (ds_r < best_d_r) ? rd_r.dest : best_p_r;
  assign k_inc   = k_r + CW'(1);

  assign stat.count_zero = (count_r == '0);
  assign stat.merge      = merge_r;
  assign stat.split      = (len_r > {backlog_r, 1'b0});
  assign stat.clean_go   = (total_r < fpm_pkg::TOTAL_W'(backlog_r)) && (keep_r < count_r);
  assign stat.hit        = hit_r;
  assign stat.last       = (k_inc == count_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = nidx_r;
    wr_data = rd_r;
    mul_a   = rd_r.len;
    mul_b   = rd_r.ratio;
    case (cmd.op)
      fpm_pkg::CMD_RD_NEWEST: begin
        rd_en   = 1'b1;
        rd_addr = oldest_r + count_r[IW-1:0] - IW'(1);
      end
      fpm_pkg::CMD_WR_LEN: begin
        wr_en       = 1'b1;
        wr_data.len = len_r;
      end
      fpm_pkg::CMD_SPLIT_MUL: begin
        wr_en       = 1'b1;
        wr_data.len = d_r;
        mul_a       = d_r;
        mul_b       = rat_r;
      end
      fpm_pkg::CMD_APPEND: begin
        wr_en   = 1'b1;
        wr_data = app_r;
        wr_addr = count_r[IW] ? oldest_r : oldest_r + count_r[IW-1:0];
      end
      fpm_pkg::CMD_CL_RD: begin
        rd_en   = 1'b1;
        rd_addr = oldest_r + count_r[IW-1:0] - keep_r[IW-1:0] - IW'(1);
      end
      fpm_pkg::CMD_SR_START: begin
        rd_en   = 1'b1;
        rd_addr = oldest_r;
      end
      fpm_pkg::CMD_SR_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = oldest_r + k_inc[IW-1:0];
      end
      fpm_pkg::CMD_SR_HITMUL: begin
        mul_a = off_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r  <= '0;
      count_r   <= '0;
      backlog_r <= fpm_pkg::BACKLOG_RESET;
    end else begin
      if (cfg_wen) begin
        backlog_r <= cfg_wdata;
      end
      case (cmd.op)
        fpm_pkg::CMD_APPEND: begin
          if (count_r[IW]) begin
            oldest_r <= oldest_r + IW'(1);
          end else begin
            count_r <= count_r + CW'(1);
          end
        end
        fpm_pkg::CMD_CL_END: begin
          oldest_r <= oldest_r + IW'(count_r - keep_r);
          count_r  <= keep_r;
        end
        fpm_pkg::CMD_CL_ACC: begin
          if (op_r == fpm_pkg::OP_CLEAR) begin
            oldest_r <= '0;
            count_r  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fpm_pkg::CMD_LATCH: begin
        op_r  <= in_tuser;
        src_r <= in_tdata[47:0];
        cnt_r <= in_tdata[67:48];
        dst_r <= in_tdata[115:68];
        rat_r <= in_tdata[139:116];
      end
      fpm_pkg::CMD_RD_NEWEST: begin
        nidx_r <= oldest_r + count_r[IW-1:0] - IW'(1);
      end
      fpm_pkg::CMD_MUL_SEG, fpm_pkg::CMD_SPLIT_MUL, fpm_pkg::CMD_SR_HITMUL: begin
        prod_r <= mul_p;
      end
      fpm_pkg::CMD_MERGE_CHK: begin
        merge_r <= c_src && c_rat && c_dst;
        len_r   <= lsum[LW] ? {LW{1'b1}} : lsum[LW-1:0];
      end
      fpm_pkg::CMD_APP_IN: begin
        app_r.src   <= src_r;
        app_r.dest  <= dst_r;
        app_r.len   <= LW'(cnt_r);
        app_r.ratio <= rat_r;
      end
      fpm_pkg::CMD_SPLIT_D: begin
        d_r <= len_r - LW'(backlog_r);
      end
      fpm_pkg::CMD_APP_SPLIT: begin
        app_r.src   <= rd_r.src + PW'(d_r);
        app_r.dest  <= rd_r.dest + PW'(fpm_pkg::fpm_round(prod_r));
        app_r.len   <= LW'(backlog_r);
        app_r.ratio <= rat_r;
      end
      fpm_pkg::CMD_WR_LEN, fpm_pkg::CMD_APPEND: begin
        total_r <= '0;
        keep_r  <= '0;
      end
      fpm_pkg::CMD_CL_ACC: begin
        if (op_r == fpm_pkg::OP_CLEAR) begin
          keep_r  <= '0;
          total_r <= '0;
        end else begin
          keep_r  <= keep_r + CW'(1);
          total_r <= total_r + fpm_pkg::TOTAL_W'(rd_r.len);
        end
      end
      fpm_pkg::CMD_SR_EMPTY: begin
        res_p_r <= '0;
        res_a_r <= 1'b1;
      end
      fpm_pkg::CMD_SR_START: begin
        k_r      <= '0;
        best_d_r <= {fpm_pkg::DIST_W{1'b1}};
        best_p_r <= '0;
      end
      fpm_pkg::CMD_SR_EVAL: begin
        hit_r  <= s_hit;
        off_r  <= LW'(src_r - rd_r.src);
        ds_r   <= fpm_pkg::fpm_sat(ad_s);
        de_r   <= fpm_pkg::fpm_sat(ad_e);
        prod_r <= mul_p;
      end
      fpm_pkg::CMD_SR_NEXT: begin
        k_r <= k_inc;
        if (de_r < b1_d) begin
          best_d_r <= de_r;
          best_p_r <= end_pos;
        end else begin
          best_d_r <= b1_d;
          best_p_r <= b1_p;
        end
      end
      fpm_pkg::CMD_SR_FIN: begin
        res_p_r <= best_p_r;
        res_a_r <= 1'b1;
      end
      fpm_pkg::CMD_SR_HITRES: begin
        res_p_r <= end_pos;
        res_a_r <= 1'b0;
      end
      fpm_pkg::CMD_LOAD_OUT: begin
        out_p_r <= res_p_r;
        out_a_r <= res_a_r;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame position map testbench
// Drives a directed table and then random insert, search, clear and no-op
// requests through the stream ports under several backlog settings. An internal
// copy of the segment ring predicts each search result that the table does not fix,
// and each result leaving the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import fpm_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam logic [63:0] POS_MASK = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] LEN_MAX = 64'hFF_FFFF;
  localparam logic [63:0] FAR_DIST = 64'd2147483647;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [POS_W-1:0] frame;
    logic             approx;
  } map_result_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   src;
    logic [FCNT_W-1:0]  cnt;
    logic [POS_W-1:0]   dst;
    logic [RATIO_W-1:0] ratio;
    bit                 typed;
    map_result_t        res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [OP_W-1:0] in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wen;
  logic [BACKLOG_W-1:0] cfg_wdata;

  logic [63:0] seg_src_q [MAX_SEGMENTS];
  logic [63:0] seg_dst_q [MAX_SEGMENTS];
  logic [63:0] seg_len_q [MAX_SEGMENTS];
  logic [63:0] seg_ratio_q [MAX_SEGMENTS];
  int unsigned ring_oldest;
  int unsigned ring_count;
  logic [63:0] backlog;

  map_result_t pending_maps[$];
  int errors;
  int burst_left;
  int hold_cycles;
  int idle_cycles;

  frame_position_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] scale_frames(logic [63:0] n, logic [63:0] r);
    return (n * r + (64'd1 << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS;
  endfunction

  function automatic int unsigned ring_slot(int unsigned k);
    return (ring_oldest + k) % MAX_SEGMENTS;
  endfunction

  function automatic logic [63:0] abs_diff(logic [63:0] a, logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic ring_append(logic [63:0] s, logic [63:0] d, logic [63:0] n,
                             logic [63:0] r);
    int unsigned i;
    if (ring_count >= MAX_SEGMENTS) begin
      ring_oldest = ring_slot(1);
      ring_count = MAX_SEGMENTS - 1;
    end
    i = ring_slot(ring_count);
    seg_src_q[i] = s & POS_MASK;
    seg_dst_q[i] = d & POS_MASK;
    seg_len_q[i] = n & LEN_MAX;
    seg_ratio_q[i] = r & LEN_MAX;
    ring_count++;
  endtask

  task automatic ring_trim();
    logic [63:0] total;
    int unsigned keep;
    total = 0;
    keep = 0;
    while (total < backlog && keep < ring_count) begin
      keep++;
      total += seg_len_q[ring_slot(ring_count - keep)];
    end
    ring_oldest = ring_slot(ring_count - keep);
    ring_count = keep;
  endtask

  task automatic ring_insert(logic [63:0] s, logic [63:0] c, logic [63:0] d,
                             logic [63:0] r);
    int unsigned n;
    logic [63:0] proj, len, cut;
    if (ring_count > 0) begin
      n = ring_slot(ring_count - 1);
      proj = seg_dst_q[n] + scale_frames(seg_len_q[n], seg_ratio_q[n]);
      if (seg_src_q[n] + seg_len_q[n] == s && seg_ratio_q[n] == r &&
          abs_diff(proj, d) <= 1) begin
        len = seg_len_q[n] + c;
        if (len > LEN_MAX) len = LEN_MAX;
        seg_len_q[n] = len;
        if (len > 2 * backlog) begin
          cut = len - backlog;
          seg_len_q[n] = cut;
          ring_append(seg_src_q[n] + cut, seg_dst_q[n] + scale_frames(cut, r), backlog, r);
        end
        ring_trim();
        return;
      end
    end
    ring_append(s, d, c, r);
    ring_trim();
  endtask

  function automatic map_result_t ring_search(logic [63:0] x);
    map_result_t res;
    logic [63:0] best_pos, best_dist, s, e, span;
    int unsigned i;
    best_pos = 0;
    best_dist = FAR_DIST;
    res.approx = 1'b1;
    for (int unsigned k = 0; k < ring_count; k++) begin
      i = ring_slot(k);
      s = seg_src_q[i];
      e = s + seg_len_q[i];
      if (x >= s && x < e) begin
        res.frame = POS_W'(seg_dst_q[i] + scale_frames(x - s, seg_ratio_q[i]));
        res.approx = 1'b0;
        return res;
      end
      span = abs_diff(s, x);
      if (span < best_dist) begin
        best_dist = span;
        best_pos = seg_dst_q[i];
      end
      span = abs_diff(e, x);
      if (span < best_dist) begin
        best_dist = span;
        best_pos = seg_dst_q[i] + scale_frames(seg_len_q[i], seg_ratio_q[i]);
      end
    end
    res.frame = POS_W'(best_pos);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Sends one request, honouring the burst and gap pattern, and updates the
  // predicted ring at the edge where the request is taken.
  task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] s,
                              logic [FCNT_W-1:0] c, logic [POS_W-1:0] d,
                              logic [RATIO_W-1:0] r, bit typed, map_result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_DATA_W'({r, d, c, s});
    do @(posedge clk); while (!in_tready);
    case (op)
      OP_INSERT: ring_insert(s, c, d, r);
      OP_SEARCH: begin
        if (typed) pending_maps = {pending_maps, res};
        else pending_maps = {pending_maps, ring_search(s)};
      end
      OP_CLEAR: begin
        ring_count = 0;
        ring_oldest = 0;
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_backlog(logic [BACKLOG_W-1:0] v);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    backlog = 64'(v);
    @(posedge clk);
  endtask

  task automatic send_random(int unsigned cnt_cap);
    int unsigned pick, n;
    logic [POS_W-1:0] s, d;
    logic [FCNT_W-1:0] c;
    logic [RATIO_W-1:0] r;
    logic [OP_W-1:0] op;
    map_result_t none;
    none = '0;
    pick = $urandom_range(0, 99);
    c = FCNT_W'($urandom_range(0, cnt_cap));
    if ($urandom_range(0, 15) == 0) c = FCNT_W'($urandom);
    case ($urandom_range(0, 3))
      0: r = RATIO_W'(1) << RATIO_FRAC_BITS;
      1: r = RATIO_W'($urandom_range(1 << 14, 1 << 18));
      default: r = RATIO_W'($urandom);
    endcase
    s = {$urandom, $urandom};
    d = {$urandom, $urandom};
    op = OP_INSERT;
    if (pick < 45 && ring_count > 0) begin
      n = ring_slot(ring_count - 1);
      s = POS_W'(seg_src_q[n] + seg_len_q[n]);
      d = POS_W'(seg_dst_q[n] + scale_frames(seg_len_q[n], seg_ratio_q[n]) +
                 64'($urandom_range(0, 3)) - 64'd1);
      if ($urandom_range(0, 7) != 0) r = RATIO_W'(seg_ratio_q[n]);
    end else if (pick < 60) begin
      if ($urandom_range(0, 1) != 0) s = POS_W'($urandom_range(0, 1 << 20));
    end else if (pick < 95) begin
      op = OP_SEARCH;
      if (ring_count > 0 && $urandom_range(0, 4) != 0) begin
        n = ring_slot($urandom_range(0, ring_count - 1));
        s = POS_W'(seg_src_q[n] + 64'($urandom_range(0, seg_len_q[n] + 6)) - 64'd3);
      end
    end else if (pick < 98) begin
      op = OP_CLEAR;
    end else begin
      op = OP_NOP;
    end
    send_request(op, s, c, d, r, 1'b0, none);
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        case (($time / 12 / 256) % 3)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 64'd0);
      end else begin
        want = pending_maps.pop_front();
        if (out_tdata !== want.frame) report_mismatch("mapped frame", out_tdata, want.frame);
        if (out_tuser !== want.approx) report_mismatch("approximate", out_tuser, want.approx);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t row(logic [OP_W-1:0] op, logic [POS_W-1:0] s,
                                    logic [FCNT_W-1:0] c, logic [POS_W-1:0] d,
                                    logic [RATIO_W-1:0] r, bit typed = 0,
                                    logic [POS_W-1:0] f = 0, logic a = 0);
    stim_row_t x;
    x.op = op; x.src = s; x.cnt = c; x.dst = d; x.ratio = r;
    x.typed = typed; x.res.frame = f; x.res.approx = a;
    return x;
  endfunction

  initial begin
    logic [BACKLOG_W-1:0] phases[6];
    logic [POS_W-1:0] top;
    int unsigned caps[6];
    top = '1;
    phases = '{23'd1, 23'd4194304, 23'd0, 23'd8388607, 23'd3000, 23'd100000};
    caps = '{4, 1000, 50, 1048575, 600, 5000};
    errors = 0;
    burst_left = 0;
    hold_cycles = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    ring_count = 0;
    ring_oldest = 0;
    backlog = 64'd100000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    directed = {directed, row(OP_SEARCH, 0, 0, 0, 0, 1, 0, 1)};
    directed = {directed, row(OP_CLEAR, 0, 0, 0, 0)};
    directed = {directed, row(OP_SEARCH, top, '1, top, '1, 1, 0, 1)};
    directed = {directed, row(OP_INSERT, 1000, 500, 2000, 24'h010000)};
    directed = {directed, row(OP_INSERT, 1500, 500, 2500, 24'h010000)};
    directed = {directed, row(OP_SEARCH, 1200, 0, 0, 0, 1, 2200, 0)};
    directed = {directed, row(OP_SEARCH, 999, 0, 0, 0, 1, 2000, 1)};
    directed = {directed, row(OP_SEARCH, 2000, 0, 0, 0, 1, 3000, 1)};
    directed = {directed, row(OP_INSERT, 2000, 100, 3001, 24'h010000)};
    directed = {directed, row(OP_INSERT, 2100, 10, 3102, 24'h018000)};
    directed = {directed, row(OP_INSERT, top, '1, top, '1)};
    directed = {directed, row(OP_SEARCH, top, 0, 0, 0)};
    directed = {directed, row(OP_SEARCH, 48'h0100_0000_0000, 0, 0, 0)};
    directed = {directed, row(OP_INSERT, 5000, 0, 9000, 0)};
    directed = {directed, row(OP_NOP, top, '1, top, '1)};
    directed = {directed, row(OP_SEARCH, 5, 0, 0, 0)};
    directed = {directed, row(OP_SEARCH, 2105, 0, 0, 0)};
    directed = {directed, row(OP_CLEAR, top, '1, top, '1)};
    directed = {directed, row(OP_SEARCH, 1200, 0, 0, 0, 1, 0, 1)};
    foreach (directed[i])
      send_request(directed[i].op, directed[i].src, directed[i].cnt, directed[i].dst,
                   directed[i].ratio, directed[i].typed, directed[i].res);

    foreach (phases[p]) begin
      write_backlog(phases[p]);
      if (p == 1) hold_cycles = 400;
      for (int i = 0; i < 85; i++) send_random(caps[p]);
      if (p == 3) wait_drained();
    end

    in_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
